>>> design/lers_pkg.sv
// ----------------------------------------------------------------------------
// lers_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles that join the lane edge row scanner controller and datapath.
// ----------------------------------------------------------------------------
package lers_pkg;

	// Default size limits of the image.
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Port widths fixed by the field definitions.
	localparam int PIX_W      = 8;
	localparam int X_W        = 10;
	localparam int CFG_LONG_W  = 11;
	localparam int CFG_SHORT_W = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_COLUMN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_ROW        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 3'd5;

	// Register values after reset.
	localparam logic [CFG_LONG_W-1:0]  RST_CENTER_COLUMN  = 11'd512;
	localparam logic [CFG_LONG_W-1:0]  RST_MIN_RUN_LENGTH = 11'd3;
	localparam logic [CFG_SHORT_W-1:0] RST_FIRST_ROW      = 10'd0;
	localparam logic [CFG_LONG_W-1:0]  RST_END_ROW        = 11'd1024;
	localparam logic [CFG_SHORT_W-1:0] RST_ROW_STEP       = 10'd1;
	localparam logic [CFG_LONG_W-1:0]  RST_ROW_WIDTH      = 11'd1024;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;         // a pixel transfer happens this cycle
		logic div_start;    // load the two mean dividers with the finished row
		logic phase_start;  // recompute the row sampling phase
		logic res_load;     // copy the quotients into the result register
	} lers_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sampled_end;  // the offered pixel closes a sampled row
		logic div_done;     // mean dividers have finished
		logic phase_done;   // phase recompute has finished
	} lers_sts_t;

endpackage

>>> design/lane_edge_row_scanner.sv
// ----------------------------------------------------------------------------
// lane_edge_row_scanner
// Scans a binary lane mask in raster order and reports, for each sampled row,
// the mean column of the chosen lane run left and right of the center.
// ----------------------------------------------------------------------------
// Usage: pixels arrive on the input channel (in_valid/in_ready, pixel,
// frame_start) one transfer per pixel in raster order; frame_start marks the
// first pixel of a frame and zeroes the row and column count. Six settings
// are written on the configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) while the block is idle; unknown indexes are ignored.
// Throughput: one pixel per clock while in_ready is high. The last pixel of
// a sampled row starts two iterative dividers that produce one quotient bit
// per cycle; the result goes to the result register once they finish.
// Pixels keep flowing meanwhile; only the next sampled row end waits until
// the result register is free, which happens when rows are too short for
// the division to finish or while the receiver stalls.
// After each configuration write the sampling phase is recomputed by a
// serial remainder unit, with in_ready low.
// Reset restores the register defaults and clears all scan state; no
// clearing pass is needed. A stalled result stays on the output channel
// (out_valid/out_ready and the result fields) until its transfer.
// ----------------------------------------------------------------------------
module lane_edge_row_scanner #(
	parameter int MAX_WIDTH  = lers_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lers_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Pixel input channel.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lers_pkg::PIX_W-1:0]      pixel,
	input  logic                            frame_start,
	// Row result channel.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lers_pkg::X_W-1:0]        row_index,
	output logic                            left_found,
	output logic [lers_pkg::X_W-1:0]        left_x,
	output logic                            right_found,
	output logic [lers_pkg::X_W-1:0]        right_x,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lers_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lers_pkg::CFG_DATA_W-1:0] cfg_data
);

	lers_pkg::lers_cmd_t cmd;
	lers_pkg::lers_sts_t sts;
	logic                cfg_write;

	// The controller owns all handshakes; the datapath only sees commands.
	lers_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_write (cfg_write),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Counters, run tracking, dividers and the result register.
	lers_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (pixel),
		.frame_start (frame_start),
		.row_index   (row_index),
		.left_found  (left_found),
		.left_x      (left_x),
		.right_found (right_found),
		.right_x     (right_x)
	);

endmodule

>>> design/lers_div.sv
// ----------------------------------------------------------------------------
// lers_div
// Iterative restoring divider, one quotient bit per cycle, with a one-cycle
// done pulse once quotient and remainder are final.
// ----------------------------------------------------------------------------
module lers_div #(
	parameter int DW = 20,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);

	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;

	logic [VW:0]     shifted;
	logic            fits;
	logic [VW:0]     diff;

	always_comb begin
		shifted = {rem_q, quo_q[DW-1]};
		fits    = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

>>> design/lers_dp.sv
// ----------------------------------------------------------------------------
// lers_dp
// Datapath: configuration registers, column and row counters, run tracking,
// best run per side, the two mean dividers, the phase unit and the result
// register.
// ----------------------------------------------------------------------------
module lers_dp #(
	parameter int MAX_WIDTH  = lers_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lers_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lers_pkg::lers_cmd_t             cmd,
	output lers_pkg::lers_sts_t             sts,
	input  logic                            cfg_write,
	input  logic [lers_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lers_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [lers_pkg::PIX_W-1:0]      pixel,
	input  logic                            frame_start,
	output logic [lers_pkg::X_W-1:0]        row_index,
	output logic                            left_found,
	output logic [lers_pkg::X_W-1:0]        left_x,
	output logic                            right_found,
	output logic [lers_pkg::X_W-1:0]        right_x
);

	localparam int LW   = lers_pkg::CFG_LONG_W;
	localparam int SHW  = lers_pkg::CFG_SHORT_W;
	localparam int XW   = lers_pkg::X_W;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int NW   = $clog2(MAX_WIDTH + 1);
	localparam int SW   = 2 * CW;
	localparam int WW   = (NW > LW) ? NW : LW;
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int RCW  = (RW > LW) ? RW : LW;

	// Configuration registers.
	logic [LW-1:0]  center_q;
	logic [LW-1:0]  min_run_q;
	logic [SHW-1:0] first_row_q;
	logic [LW-1:0]  end_row_q;
	logic [SHW-1:0] row_step_q;
	logic [LW-1:0]  row_width_q;

	// Scan state.
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [SHW-1:0] phase_q;
	logic [NW-1:0]  run_len_q;
	logic [SW-1:0]  run_sum_q;
	logic [NW-1:0]  lbest_len_q;
	logic [SW-1:0]  lbest_sum_q;
	logic           lvalid_q;
	logic [NW-1:0]  rbest_len_q;
	logic [SW-1:0]  rbest_sum_q;
	logic           rvalid_q;

	// Row waiting for its means.
	logic [RW-1:0]  pend_row_q;
	logic           pend_lv_q;
	logic           pend_rv_q;

	// Result register.
	logic [XW-1:0]  res_row_q;
	logic           res_lf_q;
	logic [XW-1:0]  res_lx_q;
	logic           res_rf_q;
	logic [XW-1:0]  res_rx_q;

	// Effective settings.
	logic [WW-1:0]  width_raw;
	logic [WW-1:0]  width;
	logic [WW-1:0]  center_raw;
	logic [WW-1:0]  center;
	logic [WW-1:0]  need;
	logic [SHW-1:0] step;
	logic [WW-1:0]  last;

	// State seen by the offered pixel, after a frame start clears it.
	logic [CW-1:0]  col;
	logic [RW-1:0]  row;
	logic [SHW-1:0] phase;
	logic [NW-1:0]  run_len;
	logic [SW-1:0]  run_sum;
	logic           lvalid;
	logic           rvalid;

	logic           white;
	logic           row_end;
	logic           sampled;
	logic           on_left;
	logic           close;
	logic           qualify;
	logic [NW-1:0]  len1;
	logic [SW-1:0]  sum1;

	// State after this pixel, before the row end clears it.
	logic [NW-1:0]  run_len_n;
	logic [SW-1:0]  run_sum_n;
	logic [NW-1:0]  lbest_len_n;
	logic [SW-1:0]  lbest_sum_n;
	logic           lvalid_n;
	logic [NW-1:0]  rbest_len_n;
	logic [SW-1:0]  rbest_sum_n;
	logic           rvalid_n;

	logic [RW:0]    row_inc;
	logic [RW-1:0]  row_nx;
	logic [SHW:0]   phase_inc;
	logic [SHW-1:0] phase_nx;
	logic [RW-1:0]  phase_dividend;

	logic [SW-1:0]  lquot;
	logic [SW-1:0]  rquot;
	logic [SHW-1:0] phase_rem;
	logic           ldone;
	logic           rdone;

	always_comb begin
		width_raw = WW'(row_width_q);
		if (row_width_q == '0) begin
			width = WW'(1);
		end else if (width_raw > WW'(MAX_WIDTH)) begin
			width = WW'(MAX_WIDTH);
		end else begin
			width = width_raw;
		end
		center_raw = WW'(center_q);
		center     = (center_raw > width) ? width : center_raw;
		need       = (min_run_q == '0) ? WW'(1) : WW'(min_run_q);
		step       = (row_step_q == '0) ? SHW'(1) : row_step_q;
		last       = width - WW'(1);
	end

	always_comb begin
		col     = frame_start ? '0 : col_q;
		row     = frame_start ? '0 : row_q;
		phase   = frame_start ? '0 : phase_q;
		run_len = frame_start ? '0 : run_len_q;
		run_sum = frame_start ? '0 : run_sum_q;
		lvalid  = frame_start ? 1'b0 : lvalid_q;
		rvalid  = frame_start ? 1'b0 : rvalid_q;

		white   = pixel != '0;
		row_end = WW'(col) >= last;
		sampled = (RCW'(row) >= RCW'(first_row_q)) && (RCW'(row) < RCW'(end_row_q))
			&& (phase == '0);
		on_left = WW'(col) < center;

		len1    = white ? run_len + NW'(1) : run_len;
		sum1    = white ? run_sum + SW'(col) : run_sum;
		close   = white ? ((WW'(col) + WW'(1) == center) || row_end) : 1'b1;
		qualify = WW'(len1) >= need;

		run_len_n   = run_len;
		run_sum_n   = run_sum;
		lbest_len_n = frame_start ? '0 : lbest_len_q;
		lbest_sum_n = frame_start ? '0 : lbest_sum_q;
		lvalid_n    = lvalid;
		rbest_len_n = frame_start ? '0 : rbest_len_q;
		rbest_sum_n = frame_start ? '0 : rbest_sum_q;
		rvalid_n    = rvalid;
		if (sampled) begin
			run_len_n = close ? '0 : len1;
			run_sum_n = close ? '0 : sum1;
			if (close && qualify) begin
				if (on_left) begin
					lbest_len_n = len1;
					lbest_sum_n = sum1;
					lvalid_n    = 1'b1;
				end else if (!rvalid) begin
					rbest_len_n = len1;
					rbest_sum_n = sum1;
					rvalid_n    = 1'b1;
				end
			end
		end

		row_inc   = {1'b0, row} + (RW+1)'(1);
		row_nx    = (row_inc == (RW+1)'(MAX_HEIGHT)) ? '0 : row_inc[RW-1:0];
		phase_inc = {1'b0, phase} + (SHW+1)'(1);
		if (RCW'(row_nx) == RCW'(first_row_q)) begin
			phase_nx = '0;
		end else if (phase_inc == {1'b0, step}) begin
			phase_nx = '0;
		end else begin
			phase_nx = phase_inc[SHW-1:0];
		end

		if (RCW'(row_q) >= RCW'(first_row_q)) begin
			phase_dividend = RW'(RCW'(row_q) - RCW'(first_row_q));
		end else begin
			phase_dividend = '0;
		end
	end

	assign sts.sampled_end = sampled && row_end;
	assign sts.div_done    = ldone;
	assign sts.phase_done  = phase_done_w;

	logic phase_done_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q    <= lers_pkg::RST_CENTER_COLUMN;
			min_run_q   <= lers_pkg::RST_MIN_RUN_LENGTH;
			first_row_q <= lers_pkg::RST_FIRST_ROW;
			end_row_q   <= lers_pkg::RST_END_ROW;
			row_step_q  <= lers_pkg::RST_ROW_STEP;
			row_width_q <= lers_pkg::RST_ROW_WIDTH;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lers_pkg::REG_CENTER_COLUMN:  center_q    <= cfg_data;
				lers_pkg::REG_MIN_RUN_LENGTH: min_run_q   <= cfg_data;
				lers_pkg::REG_FIRST_ROW:      first_row_q <= cfg_data[SHW-1:0];
				lers_pkg::REG_END_ROW:        end_row_q   <= cfg_data;
				lers_pkg::REG_ROW_STEP:       row_step_q  <= cfg_data[SHW-1:0];
				lers_pkg::REG_ROW_WIDTH:      row_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			phase_q     <= '0;
			run_len_q   <= '0;
			run_sum_q   <= '0;
			lbest_len_q <= '0;
			lbest_sum_q <= '0;
			lvalid_q    <= 1'b0;
			rbest_len_q <= '0;
			rbest_sum_q <= '0;
			rvalid_q    <= 1'b0;
		end else if (cmd.take) begin
			if (row_end) begin
				col_q       <= '0;
				row_q       <= row_nx;
				phase_q     <= phase_nx;
				run_len_q   <= '0;
				run_sum_q   <= '0;
				lbest_len_q <= '0;
				lbest_sum_q <= '0;
				lvalid_q    <= 1'b0;
				rbest_len_q <= '0;
				rbest_sum_q <= '0;
				rvalid_q    <= 1'b0;
			end else begin
				col_q       <= col + CW'(1);
				row_q       <= row;
				phase_q     <= phase;
				run_len_q   <= run_len_n;
				run_sum_q   <= run_sum_n;
				lbest_len_q <= lbest_len_n;
				lbest_sum_q <= lbest_sum_n;
				lvalid_q    <= lvalid_n;
				rbest_len_q <= rbest_len_n;
				rbest_sum_q <= rbest_sum_n;
				rvalid_q    <= rvalid_n;
			end
		end else if (phase_done_w) begin
			phase_q <= phase_rem;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			pend_row_q <= row;
			pend_lv_q  <= lvalid_n;
			pend_rv_q  <= rvalid_n;
		end
		if (cmd.res_load) begin
			res_row_q <= XW'(pend_row_q);
			res_lf_q  <= pend_lv_q;
			res_lx_q  <= pend_lv_q ? XW'(lquot) : '0;
			res_rf_q  <= pend_rv_q;
			res_rx_q  <= pend_rv_q ? XW'(rquot) : '0;
		end
	end

	lers_div #(.DW(SW), .VW(NW)) u_left_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (lbest_sum_n),
		.divisor  (lbest_len_n),
		.done     (ldone),
		.quot     (lquot),
		.rem      ()
	);

	lers_div #(.DW(SW), .VW(NW)) u_right_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rbest_sum_n),
		.divisor  (rbest_len_n),
		.done     (rdone),
		.quot     (rquot),
		.rem      ()
	);

	lers_div #(.DW(RW), .VW(SHW)) u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.phase_start),
		.dividend (phase_dividend),
		.divisor  (step),
		.done     (phase_done_w),
		.quot     (),
		.rem      (phase_rem)
	);

	assign row_index   = res_row_q;
	assign left_found  = res_lf_q;
	assign left_x      = res_lx_q;
	assign right_found = res_rf_q;
	assign right_x     = res_rx_q;

	// Both mean dividers are started together and must finish together.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ldone == rdone)
		else $error("left and right mean dividers out of step");

	// No pixel is taken while the phase recompute reports done.
	a_no_take_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_done_w |-> !cmd.take)
		else $error("pixel taken during phase recompute");

	// The result register changes only when a result is loaded.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.res_load) |-> $stable(res_lx_q) && $stable(res_rx_q))
		else $error("result register changed without a load");

endmodule

>>> design/lers_ctrl.sv
// ----------------------------------------------------------------------------
// lers_ctrl
// Controller: gates pixel transfers, sequences the mean division of a finished
// row into the result register and recomputes the sampling phase after a
// configuration write.
// ----------------------------------------------------------------------------
module lers_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	output logic                cfg_write,
	output lers_pkg::lers_cmd_t cmd,
	input  lers_pkg::lers_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PHASE = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_OUT   = 4'b1000
	} lers_state_t;

	lers_state_t state_q;
	lers_state_t state_d;
	logic        dirty_q;
	logic        ready;

	always_comb begin
		state_d         = state_q;
		ready           = 1'b0;
		cmd.div_start   = 1'b0;
		cmd.phase_start = 1'b0;
		cmd.res_load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (dirty_q) begin
					cmd.phase_start = 1'b1;
					state_d         = ST_PHASE;
				end else begin
					ready = 1'b1;
					if (in_valid && sts.sampled_end) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_PHASE: begin
				if (sts.phase_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				ready = !sts.sampled_end;
				if (sts.div_done) begin
					cmd.res_load = 1'b1;
					state_d      = ST_OUT;
				end
			end
			ST_OUT: begin
				ready = !sts.sampled_end;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.take = in_valid && ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				dirty_q <= 1'b1;
			end else if (cmd.phase_start) begin
				dirty_q <= 1'b0;
			end
		end
	end

	assign in_ready  = ready;
	assign out_valid = state_q == ST_OUT;
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid;

	// A second row end may not enter while a result is still being formed or presented.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && (state_q != ST_IDLE) |-> !sts.sampled_end)
		else $error("row end taken while a result is pending");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("mean division finished outside the divide state");

	a_phase_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sts.phase_done |-> state_q == ST_PHASE)
		else $error("phase recompute finished outside its state");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid)
		else $error("loaded result not presented");

endmodule
